FILE: sv/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants and types for the Sobel gradient magnitude unit.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int ROW_W      = 13;
  localparam int ABS_W      = PIXEL_BITS + 2;
  localparam int GRAD_W     = PIXEL_BITS + 3;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int MAG_W      = 11;
  localparam int RAD_W      = 2 * MAG_W - 1;
  localparam int WORD_W     = 2 * PIXEL_BITS;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);
  localparam logic [CFG_W_W-1:0] WIDTH_MAX    = CFG_W_W'(MAX_WIDTH);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: sv/sobel_gradient_magnitude_unit.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_unit
// Streaming 3x3 Sobel gradient magnitude with zero padding.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, in_pixel, in_drain    | input transfer
//  out     | out_valid, out_ready, out_magnitude,      | result transfer
//          | out_row_end, out_frame_end, out_last_of_run|
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// One item at a time: a line store read and a window update, then for each
// result the gradient, squares, sum, iterative square root and output load;
// an item gives zero, one or two results.
// After reset a clearing pass zeroes all 1024 words of the line stores; in_ready
// stays low during it. A full output register holds the sequencer in S_OUT.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_pixel,
  input  logic                           in_drain,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sgm_pkg::MAG_W-1:0]      out_magnitude,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  output logic                           out_last_of_run,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [sgm_pkg::CFG_H_W-1:0]    cfg_data
);

  localparam int PB = sgm_pkg::PIXEL_BITS;

  sgm_pkg::state_t state_r, state_nxt;

  logic [sgm_pkg::CFG_W_W-1:0] width_r;
  logic [sgm_pkg::CFG_H_W-1:0] height_r;
  logic [sgm_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [sgm_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [sgm_pkg::COL_W-1:0]   clr_r, clr_nxt;

  logic [sgm_pkg::COL_W-1:0]   idx_r, idx_nxt;
  logic [PB-1:0]               pix_r, pix_nxt;
  logic                        last_r, last_nxt;
  logic                        drain_r, drain_nxt;
  logic                        row1_r, row1_nxt;
  logic                        row2_r, row2_nxt;
  logic                        colnz_r, colnz_nxt;
  logic                        second_r, second_nxt;

  logic [PB-1:0]               win_r [9];
  logic [PB-1:0]               win_nxt [9];
  logic [PB-1:0]               gw [9];

  logic [sgm_pkg::ABS_W-1:0]   agx_r, agx_nxt, agy_r, agy_nxt;
  logic [sgm_pkg::SQ_W-1:0]    sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [sgm_pkg::MAG_W-1:0]   mag_r, mag_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sgm_pkg::MAG_W-1:0]   out_mag_r, out_mag_nxt;
  logic                        out_re_r, out_re_nxt;
  logic                        out_fe_r, out_fe_nxt;
  logic                        out_lr_r, out_lr_nxt;

  logic [sgm_pkg::CFG_W_W-1:0] w_eff;
  logic [sgm_pkg::CFG_H_W-1:0] h_eff;
  logic                        last_col, drain_row, accept;
  logic [PB-1:0]               top, mid;
  logic signed [sgm_pkg::GRAD_W-1:0] gx, gy;
  logic [sgm_pkg::RAD_W-1:0]   rad;

  logic                        rd_en, wr_en;
  logic [sgm_pkg::COL_W-1:0]   wr_addr;
  logic [sgm_pkg::WORD_W-1:0]  rd_data, wr_data;

  sgm_pkg::sqrt_req_t sq_req;
  sgm_pkg::sqrt_rsp_t sq_rsp;

  sgm_line_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sgm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    if (width_r == '0) begin
      w_eff = sgm_pkg::CFG_W_W'(1);
    end else if (width_r > sgm_pkg::WIDTH_MAX) begin
      w_eff = sgm_pkg::WIDTH_MAX;
    end else begin
      w_eff = width_r;
    end
    h_eff     = (height_r == '0) ? sgm_pkg::CFG_H_W'(1) : height_r;
    last_col  = {1'b0, col_r} >= (w_eff - sgm_pkg::CFG_W_W'(1));
    drain_row = row_r >= h_eff;
    top       = row2_r ? rd_data[sgm_pkg::WORD_W-1:PB] : '0;
    mid       = row1_r ? rd_data[PB-1:0] : '0;
    for (int i = 0; i < 3; i++) begin
      if (second_r) begin
        gw[3*i]   = win_r[3*i+1];
        gw[3*i+1] = win_r[3*i+2];
        gw[3*i+2] = '0;
      end else begin
        gw[3*i]   = win_r[3*i];
        gw[3*i+1] = win_r[3*i+1];
        gw[3*i+2] = win_r[3*i+2];
      end
    end
    gx = (sgm_pkg::GRAD_W'(gw[0]) + (sgm_pkg::GRAD_W'(gw[1]) << 1) + sgm_pkg::GRAD_W'(gw[2]))
       - (sgm_pkg::GRAD_W'(gw[6]) + (sgm_pkg::GRAD_W'(gw[7]) << 1) + sgm_pkg::GRAD_W'(gw[8]));
    gy = (sgm_pkg::GRAD_W'(gw[0]) + (sgm_pkg::GRAD_W'(gw[3]) << 1) + sgm_pkg::GRAD_W'(gw[6]))
       - (sgm_pkg::GRAD_W'(gw[2]) + (sgm_pkg::GRAD_W'(gw[5]) << 1) + sgm_pkg::GRAD_W'(gw[8]));
    rad = sgm_pkg::RAD_W'(sqx_r) + sgm_pkg::RAD_W'(sqy_r);
  end

  assign in_ready = (state_r == sgm_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    drain_nxt     = drain_r;
    row1_nxt      = row1_r;
    row2_nxt      = row2_r;
    colnz_nxt     = colnz_r;
    second_nxt    = second_r;
    agx_nxt       = agx_r;
    agy_nxt       = agy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mag_nxt   = out_mag_r;
    out_re_nxt    = out_re_r;
    out_fe_nxt    = out_fe_r;
    out_lr_nxt    = out_lr_r;
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = {mid, pix_r};
    sq_req.start    = 1'b0;
    sq_req.radicand = rad;

    case (state_r)
      sgm_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + sgm_pkg::COL_W'(1);
        if (clr_r == sgm_pkg::COL_W'(sgm_pkg::MAX_WIDTH - 1)) begin
          state_nxt = sgm_pkg::S_IDLE;
        end
      end
      sgm_pkg::S_IDLE: begin
        if (accept) begin
          rd_en     = 1'b1;
          idx_nxt   = col_r;
          pix_nxt   = (drain_row || in_drain) ? '0 : in_pixel[PB-1:0];
          last_nxt  = last_col;
          drain_nxt = drain_row;
          row1_nxt  = row_r >= sgm_pkg::ROW_W'(1);
          row2_nxt  = row_r >= sgm_pkg::ROW_W'(2);
          colnz_nxt = col_r != '0;
          if (last_col) begin
            col_nxt = '0;
            row_nxt = drain_row ? '0 : row_r + sgm_pkg::ROW_W'(1);
          end else begin
            col_nxt = col_r + sgm_pkg::COL_W'(1);
          end
          state_nxt = sgm_pkg::S_READ;
        end
      end
      sgm_pkg::S_READ: begin
        wr_en = 1'b1;
        for (int i = 0; i < 3; i++) begin
          win_nxt[3*i]   = colnz_r ? win_r[3*i+1] : '0;
          win_nxt[3*i+1] = colnz_r ? win_r[3*i+2] : '0;
        end
        win_nxt[2] = top;
        win_nxt[5] = mid;
        win_nxt[8] = pix_r;
        if (row1_r && colnz_r) begin
          second_nxt = 1'b0;
          state_nxt  = sgm_pkg::S_GRAD;
        end else if (row1_r && last_r) begin
          second_nxt = 1'b1;
          state_nxt  = sgm_pkg::S_GRAD;
        end else begin
          state_nxt = sgm_pkg::S_IDLE;
        end
      end
      sgm_pkg::S_GRAD: begin
        agx_nxt   = sgm_pkg::ABS_W'(gx[sgm_pkg::GRAD_W-1] ? -gx : gx);
        agy_nxt   = sgm_pkg::ABS_W'(gy[sgm_pkg::GRAD_W-1] ? -gy : gy);
        state_nxt = sgm_pkg::S_SQ;
      end
      sgm_pkg::S_SQ: begin
        sqx_nxt   = agx_r * agx_r;
        sqy_nxt   = agy_r * agy_r;
        state_nxt = sgm_pkg::S_SUM;
      end
      sgm_pkg::S_SUM: begin
        sq_req.start = 1'b1;
        state_nxt    = sgm_pkg::S_ROOT;
      end
      sgm_pkg::S_ROOT: begin
        if (sq_rsp.done) begin
          mag_nxt   = sq_rsp.root;
          state_nxt = sgm_pkg::S_OUT;
        end
      end
      sgm_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mag_nxt   = mag_r;
          if (second_r) begin
            out_re_nxt = 1'b1;
            out_fe_nxt = drain_r;
            out_lr_nxt = 1'b1;
            state_nxt  = sgm_pkg::S_IDLE;
          end else begin
            out_re_nxt = 1'b0;
            out_fe_nxt = 1'b0;
            out_lr_nxt = !last_r;
            if (last_r) begin
              second_nxt = 1'b1;
              state_nxt  = sgm_pkg::S_GRAD;
            end else begin
              state_nxt = sgm_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = sgm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgm_pkg::S_CLEAR;
      width_r     <= sgm_pkg::WIDTH_RESET;
      height_r    <= sgm_pkg::HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
      if (cfg_we) begin
        case (sgm_pkg::reg_idx_t'(cfg_index))
          sgm_pkg::REG_WIDTH:  width_r  <= cfg_data[sgm_pkg::CFG_W_W-1:0];
          sgm_pkg::REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
    idx_r     <= idx_nxt;
    pix_r     <= pix_nxt;
    last_r    <= last_nxt;
    drain_r   <= drain_nxt;
    row1_r    <= row1_nxt;
    row2_r    <= row2_nxt;
    colnz_r   <= colnz_nxt;
    second_r  <= second_nxt;
    agx_r     <= agx_nxt;
    agy_r     <= agy_nxt;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
    mag_r     <= mag_nxt;
    out_mag_r <= out_mag_nxt;
    out_re_r  <= out_re_nxt;
    out_fe_r  <= out_fe_nxt;
    out_lr_r  <= out_lr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_magnitude   = out_mag_r;
  assign out_row_end     = out_re_r;
  assign out_frame_end   = out_fe_r;
  assign out_last_of_run = out_lr_r;

endmodule

FILE: sv/sgm_line_store.sv
// ----------------------------------------------------------------------------
// sgm_line_store
// Two line stores packed as one word per column: {upper, middle}.
// ----------------------------------------------------------------------------
module sgm_line_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [sgm_pkg::COL_W-1:0]   rd_addr,
  output logic [sgm_pkg::WORD_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [sgm_pkg::COL_W-1:0]   wr_addr,
  input  logic [sgm_pkg::WORD_W-1:0]  wr_data
);

  logic [sgm_pkg::WORD_W-1:0] mem [sgm_pkg::MAX_WIDTH];
  logic [sgm_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/sgm_sqrt.sv
// ----------------------------------------------------------------------------
// sgm_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sgm_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  sgm_pkg::sqrt_req_t req,
  output sgm_pkg::sqrt_rsp_t rsp
);

  localparam logic [sgm_pkg::RAD_W-1:0] TOP_BIT =
    sgm_pkg::RAD_W'(1) << (2 * (sgm_pkg::MAG_W - 1));

  logic [sgm_pkg::RAD_W-1:0] rem_r, rem_nxt;
  logic [sgm_pkg::RAD_W-1:0] res_r, res_nxt;
  logic [sgm_pkg::RAD_W-1:0] bit_r, bit_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [sgm_pkg::RAD_W-1:0] trial;

  always_comb begin
    trial    = res_r + bit_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.radicand;
      res_nxt  = '0;
      bit_nxt  = TOP_BIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[sgm_pkg::MAG_W-1:0];

endmodule
